[hw/rtl/crpf_pkg.sv]
package crpf_pkg;

  localparam int unsigned MaxPointsDef = 16;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_RESET   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_SPEED     = 2'd0,
    CFG_LOOKAHEAD = 2'd1,
    CFG_POINTS    = 2'd2,
    CFG_SPARE     = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_EVAL_POS,
    ST_EVAL_TGT,
    ST_CLOSE,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_pt;
    logic reset_path;
    logic do_step;
    logic eval_start;
    logic eval_tgt;
    logic do_close;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eval_done;
  } sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sh7fff;
    if (v < -40'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

[hw/rtl/crpf_ctrl.sv]
module crpf_ctrl
  import crpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd,
  input  sts_t       sts
);

  state_t state_r, state_nxt;
  op_t    op;

  assign op = op_t'(in_operation);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && op == OP_ADVANCE) state_nxt = ST_STEP;
      end
      ST_STEP:     state_nxt = ST_EVAL_POS;
      ST_EVAL_POS: if (sts.eval_done) state_nxt = ST_EVAL_TGT;
      ST_EVAL_TGT: if (sts.eval_done) state_nxt = ST_CLOSE;
      ST_CLOSE:    state_nxt = ST_OUT;
      ST_OUT:      if (out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // outputs
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_pt    = in_valid && op == OP_LOAD;
        cmd.reset_path = in_valid && op == OP_RESET;
        cmd.do_step    = in_valid && op == OP_ADVANCE;
      end
      ST_STEP:     cmd.eval_start = 1'b1;
      ST_EVAL_POS: begin
        cmd.eval_start = sts.eval_done;
        cmd.eval_tgt   = sts.eval_done;
      end
      ST_EVAL_TGT: cmd.do_close = sts.eval_done;
      ST_CLOSE:    ;
      ST_OUT:      out_valid = 1'b1;
      default:     ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_adv_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_step |=> state_r == ST_STEP) else $error("advance not started");
`endif

endmodule

[hw/rtl/crpf_datapath.sv]
module crpf_datapath
  import crpf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [3:0]         in_point_index,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_coord_z,
  input  logic [15:0]        in_tick_time,
  output logic signed [15:0] out_position_x,
  output logic signed [15:0] out_position_y,
  output logic signed [15:0] out_position_z,
  output logic signed [15:0] out_target_x,
  output logic signed [15:0] out_target_y,
  output logic signed [15:0] out_target_z,
  output logic [16:0]        out_path_parameter,
  output logic               out_moving_backward
);

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  // configuration registers
  logic [15:0] speed_r, look_r;
  logic [4:0]  npts_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= 16'd1311;
      look_r  <= 16'd1311;
      npts_r  <= 5'd9;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPEED:     speed_r <= cfg_data;
        CFG_LOOKAHEAD: look_r  <= cfg_data;
        CFG_POINTS:    npts_r  <= cfg_data[4:0];
        default:       ;
      endcase
    end
  end

  // point memory, one entry read per cycle
  logic [47:0] mem [MAX_POINTS];
  logic [47:0] rd_r;
  logic [IW-1:0] rd_addr;
  always_ff @(posedge clk) begin
    if (cmd.load_pt && 32'(in_point_index) < MAX_POINTS)
      mem[IW'(in_point_index)] <= {in_coord_x, in_coord_y, in_coord_z};
    rd_r <= mem[rd_addr];
  end

  // path parameter and direction
  logic [16:0] par_r;
  logic        back_r;
  logic [16:0] tgt_par_r;
  logic [31:0] stp_prod;
  logic signed [18:0] pn;
  logic        bn;
  logic signed [18:0] tn;
  assign stp_prod = speed_r * in_tick_time;
  always_comb begin
    pn = back_r ? 19'(signed'({2'b0, par_r})) - 19'(stp_prod[31:16])
                : 19'(signed'({2'b0, par_r})) + 19'(stp_prod[31:16]);
    bn = back_r;
    if (pn >= 19'sd65536) begin pn = 19'sd65536; bn = 1'b1; end
    if (pn <= 19'sd0) begin pn = 19'sd0; bn = 1'b0; end
    tn = bn ? pn - 19'(look_r) : pn + 19'(look_r);
    if (tn < 19'sd0) tn = 19'sd0;
    if (tn > 19'sd65536) tn = 19'sd65536;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r  <= '0;
      back_r <= 1'b0;
    end else if (cmd.reset_path) begin
      par_r  <= '0;
      back_r <= 1'b0;
    end else if (cmd.do_step) begin
      par_r     <= pn[16:0];
      back_r    <= bn;
      tgt_par_r <= tn[16:0];
    end
  end

  // evaluation sequencer: setup, fetch 4 points, accumulate 3 coords
  logic [CW-1:0] npts;
  always_comb begin
    if (npts_r < 5'd4) npts = CW'(4);
    else if (32'(npts_r) > MAX_POINTS) npts = CW'(MAX_POINTS);
    else npts = CW'(npts_r);
  end

  logic [3:0]  ph_r;
  logic        busy_r;
  logic        tgt_sel_r;
  logic        use_tgt;
  logic [CW-1:0] seg_r;
  logic [16:0] u_r, u2_r, u3_r;
  logic [IW+16:0] scaled;
  logic [CW-1:0]  segs;
  logic [33:0] sq;
  logic signed [39:0] acc_r [3];
  logic signed [15:0] p_r [4][3];
  logic signed [15:0] res_r [3];
  logic signed [15:0] pos_r [3];

  // parameter under evaluation stays selected for the whole pass
  assign use_tgt = cmd.eval_start ? cmd.eval_tgt : tgt_sel_r;
  assign segs = npts - CW'(3);
  assign scaled = (IW + 17)'((use_tgt ? tgt_par_r : par_r) * segs);

  always_comb begin
    rd_addr = IW'(seg_r + CW'(ph_r - 4'd2));
    sq      = (ph_r == 4'd1) ? u_r * u_r : u2_r * u_r;
  end

  // per-coordinate accumulation terms
  logic signed [19:0] ca [3], cb [3], cd [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ca[c] = 20'(p_r[2][c]) - 20'(p_r[0][c]);
      cb[c] = 20'(20'(p_r[0][c]) * 2 - 20'(p_r[1][c]) * 5 + 20'(p_r[2][c]) * 4
              - 20'(p_r[3][c]));
      cd[c] = 20'(-20'(p_r[0][c]) + 20'(p_r[1][c]) * 3 - 20'(p_r[2][c]) * 3
              + 20'(p_r[3][c]));
    end
  end

  logic [1:0]  cc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
    end else if (cmd.eval_start) begin
      busy_r    <= 1'b1;
      ph_r      <= '0;
      tgt_sel_r <= cmd.eval_tgt;
      seg_r  <= (32'(scaled[IW+16:16]) > 32'(segs) - 1) ? segs - CW'(1)
                : CW'(scaled[IW+16:16]);
    end else if (busy_r) begin
      ph_r <= ph_r + 4'd1;
      unique case (ph_r)
        4'd0: u_r  <= 17'(scaled - ((IW + 17)'(seg_r) << 16));
        4'd1: u2_r <= sq[32:16];
        4'd2: u3_r <= sq[32:16];
        4'd3, 4'd4, 4'd5, 4'd6: begin
          // memory data is registered, so it comes from the address of the previous phase
          p_r[2'(ph_r - 4'd3)][0] <= rd_r[47:32];
          p_r[2'(ph_r - 4'd3)][1] <= rd_r[31:16];
          p_r[2'(ph_r - 4'd3)][2] <= rd_r[15:0];
        end
        4'd7: begin
          cc_r <= '0;
        end
        4'd8, 4'd9, 4'd10: begin
          acc_r[cc_r] <= 40'(p_r[1][cc_r]) * 131072
                         + 40'(ca[cc_r] * signed'({1'b0, u_r}));
          cc_r <= cc_r + 2'd1;
        end
        4'd11, 4'd12, 4'd13: begin
          acc_r[2'(ph_r - 4'd11)] <= acc_r[2'(ph_r - 4'd11)]
            + 40'(cb[2'(ph_r - 4'd11)] * signed'({1'b0, u2_r}));
        end
        4'd14: begin
          for (int c = 0; c < 3; c++)
            acc_r[c] <= acc_r[c] + 40'(cd[c] * signed'({1'b0, u3_r}));
        end
        default: begin
          busy_r <= 1'b0;
          for (int c = 0; c < 3; c++) res_r[c] <= sat16(acc_r[c] >>> 17);
        end
      endcase
    end
  end

  // done pulses in the same cycle as the results latch
  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else        done_r <= busy_r && ph_r == 4'd15;
  end
  assign sts.eval_done = done_r;

  always_ff @(posedge clk) begin
    if (cmd.eval_tgt) pos_r <= res_r;
  end

  // closeness test and output registers
  logic signed [16:0] dx, dy, dz;
  logic [35:0] d2;
  assign dx = 17'(res_r[0]) - 17'(pos_r[0]);
  assign dy = 17'(res_r[1]) - 17'(pos_r[1]);
  assign dz = 17'(res_r[2]) - 17'(pos_r[2]);
  assign d2 = 36'(dx * dx) + 36'(dy * dy) + 36'(dz * dz);

  always_ff @(posedge clk) begin
    if (cmd.do_close) begin
      out_position_x <= pos_r[0];
      out_position_y <= pos_r[1];
      out_position_z <= pos_r[2];
      if (d2 < 36'd7) begin
        out_target_x <= pos_r[0];
        out_target_y <= pos_r[1];
        out_target_z <= sat16(40'(pos_r[2]) - 40'sd256);
      end else begin
        out_target_x <= res_r[0];
        out_target_y <= res_r[1];
        out_target_z <= res_r[2];
      end
      out_path_parameter  <= par_r;
      out_moving_backward <= back_r;
    end
  end

`ifndef SYNTHESIS
  a_par_range: assert property (@(posedge clk) disable iff (!rst_n)
    par_r <= 17'd65536) else $error("parameter out of range");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done not a pulse");
  a_seg_ok: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> 32'(seg_r) + 3 < 32'(npts) + 1) else $error("segment out of range");
`endif

endmodule

[hw/rtl/catmull_rom_path_follower.sv]
// Catmull-Rom path follower. Load items write one control point; reset-path
// items clear the path parameter and direction. An advance item steps the parameter, then
// evaluates position and look target one after the other on a shared sequencer
// (each pass: three parameter powers, four memory reads, three terms per
// coordinate, saturation and a done pulse); the next item is taken the cycle
// after the advance result has been accepted. Configuration writes are taken
// any time and should be made only while idle.
module catmull_rom_path_follower
  import crpf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_point_index,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_coord_z,
  input  logic [15:0]        in_tick_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_position_x,
  output logic signed [15:0] out_position_y,
  output logic signed [15:0] out_position_z,
  output logic signed [15:0] out_target_x,
  output logic signed [15:0] out_target_y,
  output logic signed [15:0] out_target_z,
  output logic [16:0]        out_path_parameter,
  output logic               out_moving_backward
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  crpf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation,
    .out_valid, .out_ready, .cmd, .sts
  );

  crpf_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_valid, .cfg_index, .cfg_data,
    .in_point_index, .in_coord_x, .in_coord_y, .in_coord_z, .in_tick_time,
    .out_position_x, .out_position_y, .out_position_z,
    .out_target_x, .out_target_y, .out_target_z,
    .out_path_parameter, .out_moving_backward
  );

endmodule

[tb/crpf_checker.sv]
`timescale 1ns / 1ps
module crpf_checker
  import crpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_point_index,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_coord_z,
  input  logic [15:0]        in_tick_time,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_position_x,
  input  logic signed [15:0] out_position_y,
  input  logic signed [15:0] out_position_z,
  input  logic signed [15:0] out_target_x,
  input  logic signed [15:0] out_target_y,
  input  logic signed [15:0] out_target_z,
  input  logic [16:0]        out_path_parameter,
  input  logic               out_moving_backward,
  output int                 fail_count,
  output int                 pending_count,
  output int                 advance_count
);

  typedef struct packed {
    logic signed [15:0] pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z;
    logic [16:0]        param;
    logic               backward;
  } pose_t;

  logic signed [15:0] pt_x [16];
  logic signed [15:0] pt_y [16];
  logic signed [15:0] pt_z [16];
  logic [16:0] param_q;
  logic        backward_q;
  logic [15:0] speed_q, look_q;
  logic [4:0]  points_q;
  pose_t pose_q [$];

  function automatic longint floor_sh(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // evaluate the spline at parameter t for one coordinate table
  function automatic longint spline_coord(longint t, int c);
    longint n, segs, scaled, seg, u, u2, u3, p0, p1, p2, p3, s;
    n = points_q;
    if (n < 4) n = 4;
    if (n > 16) n = 16;
    segs = n - 3;
    scaled = t * segs;
    seg = scaled >> 16;
    if (seg > segs - 1) seg = segs - 1;
    u = scaled - (seg << 16);
    u2 = floor_sh(u * u, 16);
    u3 = floor_sh(u2 * u, 16);
    case (c)
      0: begin p0 = pt_x[seg]; p1 = pt_x[seg+1]; p2 = pt_x[seg+2]; p3 = pt_x[seg+3]; end
      1: begin p0 = pt_y[seg]; p1 = pt_y[seg+1]; p2 = pt_y[seg+2]; p3 = pt_y[seg+3]; end
      default: begin
        p0 = pt_z[seg]; p1 = pt_z[seg+1]; p2 = pt_z[seg+2]; p3 = pt_z[seg+3];
      end
    endcase
    s = 2 * p1 * 65536 + (p2 - p0) * u + (2*p0 - 5*p1 + 4*p2 - p3) * u2
        + (-p0 + 3*p1 - 3*p2 + p3) * u3;
    return clip16(floor_sh(s, 17));
  endfunction

  // step the parameter and compute the resulting pose
  function automatic pose_t advance_pose(logic [15:0] tick);
    longint stp, p, ta, d2;
    longint pos [3];
    longint tgt [3];
    pose_t r;
    stp = (longint'(speed_q) * longint'(tick)) >> 16;
    p = longint'(param_q) + (backward_q ? -stp : stp);
    if (p >= 65536) begin p = 65536; backward_q = 1'b1; end
    if (p <= 0) begin p = 0; backward_q = 1'b0; end
    param_q = p[16:0];
    ta = p + (backward_q ? -longint'(look_q) : longint'(look_q));
    if (ta < 0) ta = 0;
    if (ta > 65536) ta = 65536;
    for (int c = 0; c < 3; c++) begin
      pos[c] = spline_coord(p, c);
      tgt[c] = spline_coord(ta, c);
    end
    d2 = (tgt[0]-pos[0])*(tgt[0]-pos[0]) + (tgt[1]-pos[1])*(tgt[1]-pos[1])
         + (tgt[2]-pos[2])*(tgt[2]-pos[2]);
    // too close: look straight down from the position
    if (d2 < 7) begin
      tgt[0] = pos[0];
      tgt[1] = pos[1];
      tgt[2] = clip16(pos[2] - 256);
    end
    r.pos_x = 16'(pos[0]); r.pos_y = 16'(pos[1]); r.pos_z = 16'(pos[2]);
    r.tgt_x = 16'(tgt[0]); r.tgt_y = 16'(tgt[1]); r.tgt_z = 16'(tgt[2]);
    r.param = param_q;
    r.backward = backward_q;
    return r;
  endfunction

  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      param_q = '0;
      backward_q = 1'b0;
      speed_q = 16'd1311;
      look_q = 16'd1311;
      points_q = 5'd9;
      fail_count <= 0;
      advance_count <= 0;
      pose_q.delete();
      pending_count <= 0;
    end else begin
      // configuration transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SPEED:     speed_q = cfg_data;
          CFG_LOOKAHEAD: look_q = cfg_data;
          CFG_POINTS:    points_q = cfg_data[4:0];
          default: ;
        endcase
      end
      // input transaction
      if (in_valid && in_ready) begin
        case (op_t'(in_operation))
          OP_LOAD: begin
            pt_x[in_point_index] = in_coord_x;
            pt_y[in_point_index] = in_coord_y;
            pt_z[in_point_index] = in_coord_z;
          end
          OP_RESET: begin
            param_q = '0;
            backward_q = 1'b0;
          end
          OP_ADVANCE: begin
            pose_q.push_back(advance_pose(in_tick_time));
            advance_count <= advance_count + 1;
          end
          default: ;
        endcase
      end
      // result transaction
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          e = pose_q.pop_front();
          if ({out_position_x, out_position_y, out_position_z, out_target_x,
               out_target_y, out_target_z, out_path_parameter,
               out_moving_backward} != e) begin
            if (out_position_x != e.pos_x)
              $error("position_x exp %0d got %0d", e.pos_x, out_position_x);
            if (out_position_y != e.pos_y)
              $error("position_y exp %0d got %0d", e.pos_y, out_position_y);
            if (out_position_z != e.pos_z)
              $error("position_z exp %0d got %0d", e.pos_z, out_position_z);
            if (out_target_x != e.tgt_x)
              $error("target_x exp %0d got %0d", e.tgt_x, out_target_x);
            if (out_target_y != e.tgt_y)
              $error("target_y exp %0d got %0d", e.tgt_y, out_target_y);
            if (out_target_z != e.tgt_z)
              $error("target_z exp %0d got %0d", e.tgt_z, out_target_z);
            if (out_path_parameter != e.param)
              $error("path_parameter exp %0d got %0d", e.param, out_path_parameter);
            if (out_moving_backward != e.backward)
              $error("moving_backward exp %0d got %0d", e.backward,
                     out_moving_backward);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= pose_q.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import crpf_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] in_operation;
  logic [3:0] in_point_index;
  logic signed [15:0] in_coord_x, in_coord_y, in_coord_z;
  logic [15:0] in_tick_time;
  logic out_valid, out_ready;
  logic signed [15:0] out_position_x, out_position_y, out_position_z;
  logic signed [15:0] out_target_x, out_target_y, out_target_z;
  logic [16:0] out_path_parameter;
  logic out_moving_backward;
  int fail_count, pending_count, advance_count;
  int send_idle_pct, stall_pct, hold_cycles, quiet_cycles;
  int hold_req, hold_seen;

  catmull_rom_path_follower i_dut (.*);
  crpf_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 300;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on idle cycles
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [3:0] idx, logic [15:0] x,
                           logic [15:0] y, logic [15:0] z, logic [15:0] tick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_point_index <= idx;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_tick_time <= tick;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    // idle first: all results back, then allow the block to settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // load all 16 entries, more than the current point count may read
  task automatic load_table(int mode);
    logic [15:0] v [3];
    for (int i = 0; i < 16; i++) begin
      for (int c = 0; c < 3; c++)
        case (mode)
          0: v[c] = 16'h7fff;
          1: v[c] = 16'h8000;
          2: v[c] = (i % 2) ? 16'h7fff : 16'h8000;
          3: v[c] = 16'h0100 * i[7:0];
          default: v[c] = 16'($urandom);
        endcase
      send_item(OP_LOAD, i[3:0], v[0], v[1], v[2], '0);
    end
  endtask

  task automatic random_items(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 70)
        send_item(OP_ADVANCE, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000)));
      else if (r < 85)
        send_item(OP_LOAD, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
      else if (r < 93)
        send_item(OP_RESET, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
      else
        send_item(OP_NONE, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_operation = '0; in_point_index = '0;
    in_coord_x = '0; in_coord_y = '0; in_coord_z = '0; in_tick_time = '0;
    send_idle_pct = 0; stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme tables, all operations, clamping at both ends
    load_table(0);
    send_item(OP_ADVANCE, '0, '0, '0, '0, 16'hffff);
    send_item(OP_NONE, '0, '0, '0, '0, '0);
    load_table(2);
    send_item(OP_ADVANCE, '0, '0, '0, '0, 16'h0000);
    write_reg(CFG_SPEED, 16'hffff);
    write_reg(CFG_LOOKAHEAD, 16'hffff);
    send_item(OP_ADVANCE, '0, '0, '0, '0, 16'hffff);
    send_item(OP_ADVANCE, '0, '0, '0, '0, 16'hffff);
    send_item(OP_ADVANCE, '0, '0, '0, '0, 16'h8000);
    send_item(OP_RESET, '0, '0, '0, '0, '0);
    load_table(1);
    send_item(OP_ADVANCE, '0, '0, '0, '0, 16'h4000);
    write_reg(CFG_LOOKAHEAD, 16'h0000);
    send_item(OP_ADVANCE, '0, '0, '0, '0, 16'h0001);
    write_reg(CFG_POINTS, 16'd0);
    send_item(OP_ADVANCE, '0, '0, '0, '0, 16'h4000);
    write_reg(CFG_POINTS, 16'd31);
    load_table(3);
    send_item(OP_ADVANCE, '0, '0, '0, '0, 16'h4000);

    // random phases over several register settings and idle profiles
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SPEED, (ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(20000)));
      write_reg(CFG_LOOKAHEAD, (ph == 2) ? 16'h0000 : 16'($urandom_range(8000)));
      write_reg(CFG_POINTS, (ph == 4) ? 16'd4 : (ph == 5) ? 16'd16
                                      : 16'($urandom_range(4, 16)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      load_table(ph % 2 ? 4 : (ph == 0 ? 3 : 4));
      if (ph == 1) hold_req = hold_req + 1;
      random_items(200);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d advance results over directed extremes and eight random phases",
             advance_count);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[files.f]
hw/rtl/crpf_pkg.sv
hw/rtl/crpf_ctrl.sv
hw/rtl/crpf_datapath.sv
hw/rtl/catmull_rom_path_follower.sv
tb/crpf_checker.sv
tb/testbench.sv
